### hdl/bmbl_pkg.sv
// ----------------------------------------------------------------------------
// bmbl_pkg: shared types and constants for the binary market level book
// Request codes, decoded command word, best-level word and result word.
// ----------------------------------------------------------------------------
package bmbl_pkg;

    localparam int LEVELS    = 99;
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    localparam logic SIDE_YES = 1'b0;
    localparam logic SIDE_NO  = 1'b1;

    typedef logic [6:0] price_t;
    typedef logic [6:0] idx_t;

    typedef enum logic [1:0] {
        REQ_DELTA = 2'd0,
        REQ_SET   = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_RSVD  = 2'd3
    } req_t;

    // decoded operation; OP_NONE covers reserved codes and delta or set requests with bad prices
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_DELTA = 2'd1,
        OP_SET   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic               side;
        idx_t               idx;
        logic signed [31:0] amount;
    } cmd_t;

    typedef struct packed {
        price_t             yes_price;
        logic signed [31:0] yes_vol;
        price_t             no_price;
        logic signed [31:0] no_vol;
    } best_t;

    typedef struct packed {
        price_t             best_yes_price;
        logic signed [31:0] best_yes_volume;
        price_t             best_no_price;
        logic signed [31:0] best_no_volume;
        price_t             yes_ask_price;
        price_t             no_ask_price;
        logic signed [7:0]  yes_spread_cents;
        logic signed [7:0]  no_spread_cents;
        logic [7:0]         yes_mid_halves;
        logic [7:0]         no_mid_halves;
    } res_t;

endpackage

### hdl/bmbl_front.sv
// ----------------------------------------------------------------------------
// bmbl_front: request intake
// Decodes each request word into a command and queues it for the book.
// ----------------------------------------------------------------------------
module bmbl_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         req_type,
    input  logic               side,
    input  logic [6:0]         price,
    input  logic signed [31:0] amount,
    output logic               cmd_valid,
    output bmbl_pkg::cmd_t     cmd,
    input  logic               cmd_pop
);
    import bmbl_pkg::*;

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             q_mem [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cmd_t             cls;
    logic             price_ok;
    logic             wr_en;

    always_comb
    begin
        price_ok   = (price >= 7'd1) && (price <= 7'(LEVELS));
        cls.side   = side;
        cls.amount = amount;
        cls.idx    = price_ok ? (price - 7'd1) : '0;
        case (req_t'(req_type))
            REQ_DELTA: cls.op = price_ok ? OP_DELTA : OP_NONE;
            REQ_SET:   cls.op = price_ok ? OP_SET : OP_NONE;
            REQ_CLEAR: cls.op = OP_CLEAR;
            default:   cls.op = OP_NONE;
        endcase
    end

    assign full      = (count_reg == CNT_W'(CMD_DEPTH));
    assign wr_en     = push && !full;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({wr_en, cmd_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

### hdl/bmbl_book.sv
// ----------------------------------------------------------------------------
// bmbl_book: level store and best-bid search
// Two-step sequencer: read the addressed level volume, then update the
// level, search both sides for the best bid and read the best volumes.
// ----------------------------------------------------------------------------
module bmbl_book #(
    parameter int VOLUME_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  bmbl_pkg::cmd_t cmd,
    output logic           cmd_pop,
    input  logic           room,
    output logic [1:0]     inflight,
    output logic           best_valid,
    output bmbl_pkg::best_t best
);
    import bmbl_pkg::*;

    localparam int VW = VOLUME_BITS;
    localparam int EW = (VOLUME_BITS > 32) ? VOLUME_BITS : 32;
    localparam int SW = EW + 1;

    localparam logic signed [SW-1:0] VOL_MAX = {{(SW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
    localparam logic signed [SW-1:0] VOL_MIN = {{(SW - VW + 1){1'b1}}, {(VW - 1){1'b0}}};
    localparam logic signed [EW-1:0] I32_MAX = {{(EW - 31){1'b0}}, {31{1'b1}}};
    localparam logic signed [EW-1:0] I32_MIN = {{(EW - 31){1'b1}}, {31{1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_UPD  = 2'b10
    } bk_state_t;

    bk_state_t          state_reg, state_next;
    cmd_t               cur_reg;
    logic               fin_reg;
    logic [LEVELS-1:0]  yes_pres_reg, yes_pres_next;
    logic [LEVELS-1:0]  no_pres_reg, no_pres_next;
    logic signed [VW-1:0] yes_mem [LEVELS];
    logic signed [VW-1:0] no_mem [LEVELS];
    logic signed [VW-1:0] yes_rd_reg, no_rd_reg;
    logic signed [VW-1:0] wdata_reg;
    price_t             yes_best_reg, no_best_reg;
    logic               yes_hit_reg, no_hit_reg;

    logic               in_upd;
    logic               pres_bit;
    logic signed [VW-1:0] side_rd;
    logic signed [SW-1:0] base, amt_w, sat_in, sat_out;
    logic signed [VW-1:0] new_vol;
    logic               pos;
    logic               wr_lvl;
    logic               yes_we, no_we;
    price_t             yes_best_next, no_best_next;
    idx_t               yes_raddr, no_raddr;
    logic               yes_hit, no_hit;
    logic signed [VW-1:0] yes_vol, no_vol;

    function automatic price_t best_price(input logic [LEVELS-1:0] v);
        price_t p;
        int     i;
        p = '0;
        for (i = 0; i < LEVELS; i++)
        begin
            if (v[i])
            begin
                p = price_t'(i + 1);
            end
        end
        return p;
    endfunction

    function automatic logic signed [31:0] to_out(input logic signed [VW-1:0] v);
        logic signed [EW-1:0] e;
        e = EW'(v);
        if (e > I32_MAX)
        begin
            return 32'sh7fff_ffff;
        end
        if (e < I32_MIN)
        begin
            return 32'sh8000_0000;
        end
        return signed'(e[31:0]);
    endfunction

    assign in_upd   = (state_reg == ST_UPD);
    assign cmd_pop  = (state_reg == ST_IDLE) && cmd_valid && room;
    assign inflight = {1'b0, in_upd} + {1'b0, fin_reg};

    // level update arithmetic
    always_comb
    begin
        pres_bit = (cur_reg.side == SIDE_NO) ? no_pres_reg[cur_reg.idx]
                                             : yes_pres_reg[cur_reg.idx];
        side_rd  = (cur_reg.side == SIDE_NO) ? no_rd_reg : yes_rd_reg;
        base     = pres_bit ? SW'(side_rd) : '0;
        amt_w    = SW'(signed'(cur_reg.amount));
        sat_in   = (cur_reg.op == OP_DELTA) ? base + amt_w : amt_w;
        if (sat_in > VOL_MAX)
        begin
            sat_out = VOL_MAX;
        end
        else if (sat_in < VOL_MIN)
        begin
            sat_out = VOL_MIN;
        end
        else
        begin
            sat_out = sat_in;
        end
        new_vol = signed'(sat_out[VW-1:0]);
        pos     = !sat_in[SW-1] && (sat_in != '0);
    end

    always_comb
    begin
        yes_pres_next = yes_pres_reg;
        no_pres_next  = no_pres_reg;
        wr_lvl        = 1'b0;
        if (in_upd)
        begin
            case (cur_reg.op)
                OP_CLEAR:
                begin
                    yes_pres_next = '0;
                    no_pres_next  = '0;
                end
                OP_DELTA:
                begin
                    wr_lvl = pos;
                    if (cur_reg.side == SIDE_NO)
                        no_pres_next[cur_reg.idx] = pos;
                    else
                        yes_pres_next[cur_reg.idx] = pos;
                end
                OP_SET:
                begin
                    wr_lvl = 1'b1;
                    if (cur_reg.side == SIDE_NO)
                        no_pres_next[cur_reg.idx] = 1'b1;
                    else
                        yes_pres_next[cur_reg.idx] = 1'b1;
                end
                default:
                begin
                    wr_lvl = 1'b0;
                end
            endcase
        end
        yes_we = wr_lvl && (cur_reg.side == SIDE_YES);
        no_we  = wr_lvl && (cur_reg.side == SIDE_NO);
    end

    // best search runs on the updated presence vectors
    always_comb
    begin
        yes_best_next = best_price(yes_pres_next);
        no_best_next  = best_price(no_pres_next);
        // read port: addressed level while idle, best level during update
        if (in_upd)
        begin
            yes_raddr = (yes_best_next == '0) ? '0 : yes_best_next - 7'd1;
            no_raddr  = (no_best_next == '0) ? '0 : no_best_next - 7'd1;
        end
        else
        begin
            yes_raddr = cmd.idx;
            no_raddr  = cmd.idx;
        end
        // best level being written this cycle: take the new word directly
        yes_hit = yes_we && (yes_best_next != '0) && (cur_reg.idx == yes_best_next - 7'd1);
        no_hit  = no_we && (no_best_next != '0) && (cur_reg.idx == no_best_next - 7'd1);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (cmd_pop) state_next = ST_UPD;
            ST_UPD:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fin_reg      <= 1'b0;
            yes_pres_reg <= '0;
            no_pres_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            fin_reg      <= in_upd;
            yes_pres_reg <= yes_pres_next;
            no_pres_reg  <= no_pres_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= cmd;
        end
        if (in_upd)
        begin
            yes_best_reg <= yes_best_next;
            no_best_reg  <= no_best_next;
            yes_hit_reg  <= yes_hit;
            no_hit_reg   <= no_hit;
            wdata_reg    <= new_vol;
        end
    end

    always_ff @(posedge clk)
    begin
        if (yes_we)
        begin
            yes_mem[cur_reg.idx] <= new_vol;
        end
        yes_rd_reg <= yes_mem[yes_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (no_we)
        begin
            no_mem[cur_reg.idx] <= new_vol;
        end
        no_rd_reg <= no_mem[no_raddr];
    end

    always_comb
    begin
        yes_vol        = yes_hit_reg ? wdata_reg : yes_rd_reg;
        no_vol         = no_hit_reg ? wdata_reg : no_rd_reg;
        best.yes_price = yes_best_reg;
        best.no_price  = no_best_reg;
        best.yes_vol   = (yes_best_reg == '0) ? '0 : to_out(yes_vol);
        best.no_vol    = (no_best_reg == '0) ? '0 : to_out(no_vol);
    end

    assign best_valid = fin_reg;

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_upd && cur_reg.op == OP_CLEAR) |=> (yes_pres_reg == '0 && no_pres_reg == '0))
        else $error("book not empty after clear");

    a_upd_reports: assert property (@(posedge clk) disable iff (!rst_n)
        in_upd |=> (fin_reg && state_reg == ST_IDLE))
        else $error("update step did not hand off a best word");

    a_yes_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_reg && yes_best_reg == '0) |-> (yes_pres_reg == '0))
        else $error("yes side reported empty with a level present");

    a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_reg && no_best_reg == '0) |-> (no_pres_reg == '0))
        else $error("no side reported empty with a level present");

endmodule

### hdl/bmbl_result.sv
// ----------------------------------------------------------------------------
// bmbl_result: quote derivation and result queue
// Builds asks, spreads and midpoints from the best bids and queues words.
// ----------------------------------------------------------------------------
module bmbl_result #(
    parameter int CONTRACT_PAYOUT = 100
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            best_valid,
    input  bmbl_pkg::best_t best,
    input  logic [1:0]      inflight,
    output logic            room,
    output logic            empty,
    input  logic            pop,
    output bmbl_pkg::res_t  res
);
    import bmbl_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);
    // only the low eight bits of the payout reach any output field
    localparam logic [7:0] PAY8 = 8'(CONTRACT_PAYOUT % 256);

    res_t             q_mem [RES_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rd_en;
    logic [7:0]       ya8, na8;
    res_t             q_in;

    always_comb
    begin
        ya8 = (best.no_price == '0) ? '0 : PAY8 - {1'b0, best.no_price};
        na8 = (best.yes_price == '0) ? '0 : PAY8 - {1'b0, best.yes_price};
        q_in.best_yes_price   = best.yes_price;
        q_in.best_yes_volume  = best.yes_vol;
        q_in.best_no_price    = best.no_price;
        q_in.best_no_volume   = best.no_vol;
        q_in.yes_ask_price    = ya8[6:0];
        q_in.no_ask_price     = na8[6:0];
        q_in.yes_spread_cents = signed'(ya8 - {1'b0, best.yes_price});
        q_in.no_spread_cents  = signed'(na8 - {1'b0, best.no_price});
        q_in.yes_mid_halves   = ya8 + {1'b0, best.yes_price};
        q_in.no_mid_halves    = na8 + {1'b0, best.no_price};
    end

    // words already on their way through the book count against free space
    assign room  = ({1'b0, count_reg} + {{(CNT_W - 1){1'b0}}, inflight}) < (CNT_W + 1)'(RES_DEPTH);
    assign empty = (count_reg == '0);
    assign rd_en = pop && !empty;
    assign res   = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (best_valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({best_valid, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (best_valid)
        begin
            q_mem[wr_ptr_reg] <= q_in;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        best_valid |-> (count_reg != CNT_W'(RES_DEPTH)))
        else $error("result queue written while full");

endmodule

### hdl/binary_market_book_levels.sv
// ----------------------------------------------------------------------------
// binary_market_book_levels: two-sided price-level book for a binary contract
// Applies delta, set and clear requests to yes/no bid levels 1..99 and
// reports best bids, asks, spreads and midpoints after every request.
//
//   channel   handshake      fields
//   request   push / full    req_type, side, price, amount
//   result    pop / empty    best_*, *_ask_price, *_spread_cents, *_mid_halves
//
// The book sequencer takes a request word only after the last one's update:
// a level volume read, then the update step that writes the level and reads
// both best volumes.
// Reset clears the presence bits, not the level memories; the book takes words right after reset.
// The book stalls when queued plus in-flight words fill the result queue;
// the request queue then fills and raises full. Until then nothing stalls.
// ----------------------------------------------------------------------------
module binary_market_book_levels #(
    parameter int CONTRACT_PAYOUT = 100,
    parameter int VOLUME_BITS     = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         req_type,
    input  logic               side,
    input  logic [6:0]         price,
    input  logic signed [31:0] amount,
    output logic               empty,
    input  logic               pop,
    output logic [6:0]         best_yes_price,
    output logic signed [31:0] best_yes_volume,
    output logic [6:0]         best_no_price,
    output logic signed [31:0] best_no_volume,
    output logic [6:0]         yes_ask_price,
    output logic [6:0]         no_ask_price,
    output logic signed [7:0]  yes_spread_cents,
    output logic signed [7:0]  no_spread_cents,
    output logic [7:0]         yes_mid_halves,
    output logic [7:0]         no_mid_halves
);
    import bmbl_pkg::*;

    logic       cmd_valid;
    cmd_t       cmd;
    logic       cmd_pop;
    logic       room;
    logic [1:0] inflight;
    logic       best_valid;
    best_t      best;
    res_t       res;

    bmbl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .side      (side),
        .price     (price),
        .amount    (amount),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    bmbl_book #(
        .VOLUME_BITS (VOLUME_BITS)
    ) u_book (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .room       (room),
        .inflight   (inflight),
        .best_valid (best_valid),
        .best       (best)
    );

    bmbl_result #(
        .CONTRACT_PAYOUT (CONTRACT_PAYOUT)
    ) u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .best_valid (best_valid),
        .best       (best),
        .inflight   (inflight),
        .room       (room),
        .empty      (empty),
        .pop        (pop),
        .res        (res)
    );

    assign best_yes_price   = res.best_yes_price;
    assign best_yes_volume  = res.best_yes_volume;
    assign best_no_price    = res.best_no_price;
    assign best_no_volume   = res.best_no_volume;
    assign yes_ask_price    = res.yes_ask_price;
    assign no_ask_price     = res.no_ask_price;
    assign yes_spread_cents = res.yes_spread_cents;
    assign no_spread_cents  = res.no_spread_cents;
    assign yes_mid_halves   = res.yes_mid_halves;
    assign no_mid_halves    = res.no_mid_halves;

endmodule
